// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl file rgb_hsv_converter.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// same-cycle implication outside reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rhc_pkg.sv =====
// constants, types and the hue sector split for the colour converter
// no dependencies
package rhc_pkg;

  localparam int unsigned HUE_BITS   = 9;
  localparam int unsigned HUE_FULL   = 360;
  localparam int unsigned SECTOR_DEG = 60;

  typedef enum logic [1:0] {
    MAX_RED,
    MAX_GREEN,
    MAX_BLUE
  } max_sel_e;

  typedef struct packed {
    logic [2:0] sector;
    logic [5:0] frac;
  } hue_split_t;

  // sector index modulo six and degrees within the sector
  function automatic hue_split_t hue_split(input logic [HUE_BITS-1:0] h);
    logic [HUE_BITS-1:0] hh;
    logic [3:0]          cnt;
    hue_split_t          res;
    hh  = h;
    cnt = 4'd0;
    for (int k = 0; k < 8; k++) begin
      if (hh >= HUE_BITS'(SECTOR_DEG)) begin
        hh  = hh - HUE_BITS'(SECTOR_DEG);
        cnt = cnt + 4'd1;
      end
    end
    res.sector = (cnt >= 4'd6) ? 3'(cnt - 4'd6) : cnt[2:0];
    res.frac   = hh[5:0];
    return res;
  endfunction

endpackage

// ===== hw/rtl/rhc_if.sv =====
// valid/ready channels for the pixel input and result items
// depends on rhc_pkg for the hue width
interface rhc_in_if #(parameter int unsigned CHANNEL_BITS = 8) ();
  logic                          valid;
  logic                          ready;
  logic [CHANNEL_BITS-1:0]       red;
  logic [CHANNEL_BITS-1:0]       green;
  logic [CHANNEL_BITS-1:0]       blue;
  logic [rhc_pkg::HUE_BITS-1:0]  hue;
  logic [CHANNEL_BITS-1:0]       saturation;
  logic [CHANNEL_BITS-1:0]       brightness;
  logic [CHANNEL_BITS-1:0]       alpha;

  modport source (output valid, red, green, blue, hue, saturation, brightness, alpha,
                  input ready);
  modport sink (input valid, red, green, blue, hue, saturation, brightness, alpha,
                output ready);
endinterface

interface rhc_out_if #(parameter int unsigned CHANNEL_BITS = 8) ();
  logic                          valid;
  logic                          ready;
  logic [CHANNEL_BITS-1:0]       out_red;
  logic [CHANNEL_BITS-1:0]       out_green;
  logic [CHANNEL_BITS-1:0]       out_blue;
  logic [rhc_pkg::HUE_BITS-1:0]  out_hue;
  logic [CHANNEL_BITS-1:0]       out_saturation;
  logic [CHANNEL_BITS-1:0]       out_brightness;
  logic [CHANNEL_BITS-1:0]       out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_hue, out_saturation,
                  out_brightness, out_alpha, input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_hue, out_saturation,
                out_brightness, out_alpha, output ready);
endinterface

// ===== hw/rtl/rhc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// no dependencies; quotient must fit in QW bits
module rhc_div #(
  parameter int unsigned NW = 26,
  parameter int unsigned DW = 15,
  parameter int unsigned QW = 9
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int unsigned W = (NW > DW + QW) ? NW : DW + QW;

  logic [W-1:0]  rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [W-1:0]  rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [W-1:0]  shifted;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in = W'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = W'(den_in) << (QW - 1 - k);
    assign take    = (rem_in >= shifted);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? (rem_in - shifted) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (QW'(take) << (QW - 1 - k));
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== hw/rtl/rgb_hsv_converter.sv =====
// rgb_hsv_converter: pipelined rgb to hsv and hsv to rgb pixel converter
// depends on rhc_pkg, rhc_if, rhc_div and assert_macros.svh
//
// pix_i carries one pixel item per handshake, pix_o one result item.
// cfg_we_i/cfg_wdata_i write the direction bit: 0 rgb to hsv, 1 hsv to rgb.
// the direction is sampled with each item as it enters, so write it only
// while the pipeline is empty.
// throughput: one item per cycle while pix_o is not stalled. each item
// passes through three front stages, the bit-per-stage dividers and
// the output register.
// three divider pipelines serve the two directions: saturation and
// hue for rgb to hsv, p, q and t for hsv to rgb.
// when pix_o is stalled the whole pipeline holds; pix_i.ready drops and no
// item is lost or repeated. an empty output register never blocks input.
// reset clears the direction to 0 and all valid bits; payload is not reset.
`include "assert_macros.svh"

module rgb_hsv_converter #(
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  rhc_in_if.sink   pix_i,
  rhc_out_if.source pix_o
);

  localparam int unsigned C    = CHANNEL_BITS;
  localparam int unsigned HB   = rhc_pkg::HUE_BITS;
  localparam int unsigned NW   = 2 * C + 10;
  localparam int unsigned DW   = C + 7;
  localparam int unsigned QW   = (C > HB) ? C : HB;
  localparam int unsigned PW   = C + 6;
  localparam logic [C-1:0]  MAXV = {C{1'b1}};
  localparam logic [PW-1:0] DEN  = PW'((2 ** C - 1) * rhc_pkg::SECTOR_DEG);

  logic dir_q;
  logic en;
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  assign en          = !out_vld_q || pix_o.ready;
  assign pix_i.ready = en;

  // stage 1: extremes and hue split
  logic [C-1:0] mx_d, mn_d;
  rhc_pkg::max_sel_e sel_d;
  rhc_pkg::hue_split_t hs_d;

  always_comb begin
    mx_d = pix_i.red;
    if (pix_i.green > mx_d) mx_d = pix_i.green;
    if (pix_i.blue > mx_d) mx_d = pix_i.blue;
    mn_d = pix_i.red;
    if (pix_i.green < mn_d) mn_d = pix_i.green;
    if (pix_i.blue < mn_d) mn_d = pix_i.blue;
    if (mx_d == pix_i.red) sel_d = rhc_pkg::MAX_RED;
    else if (mx_d == pix_i.green) sel_d = rhc_pkg::MAX_GREEN;
    else sel_d = rhc_pkg::MAX_BLUE;
    hs_d = rhc_pkg::hue_split(pix_i.hue);
  end

  logic v1_q, dir1_q;
  logic [C-1:0] r1_q, g1_q, b1_q, mx1_q, mn1_q, s1_q, val1_q, a1_q;
  rhc_pkg::max_sel_e sel1_q;
  rhc_pkg::hue_split_t hs1_q;

  // stage 2: difference, hue numerator and partial products
  logic [C-1:0]  dif_d;
  logic [NW-1:0] hnum_d;
  logic [2*C-1:0] md_d;
  logic [PW-1:0] fs_d, gs_d, ps_d;

  always_comb begin
    dif_d = mx1_q - mn1_q;
    md_d  = (2*C)'(MAXV) * (2*C)'(dif_d);
    case (sel1_q)
      rhc_pkg::MAX_RED: begin
        if (g1_q >= b1_q) begin
          hnum_d = NW'(rhc_pkg::SECTOR_DEG) * (NW'(g1_q) - NW'(b1_q));
        end else begin
          hnum_d = NW'(rhc_pkg::HUE_FULL) * NW'(dif_d)
                 - NW'(rhc_pkg::SECTOR_DEG) * (NW'(b1_q) - NW'(g1_q));
        end
      end
      rhc_pkg::MAX_GREEN: begin
        hnum_d = NW'(2 * rhc_pkg::SECTOR_DEG) * NW'(dif_d)
               + NW'(rhc_pkg::SECTOR_DEG) * NW'(b1_q)
               - NW'(rhc_pkg::SECTOR_DEG) * NW'(r1_q);
      end
      default: begin
        hnum_d = NW'(4 * rhc_pkg::SECTOR_DEG) * NW'(dif_d)
               + NW'(rhc_pkg::SECTOR_DEG) * NW'(r1_q)
               - NW'(rhc_pkg::SECTOR_DEG) * NW'(g1_q);
      end
    endcase
    fs_d = PW'(hs1_q.frac) * PW'(s1_q);
    gs_d = (PW'(rhc_pkg::SECTOR_DEG) - PW'(hs1_q.frac)) * PW'(s1_q);
    ps_d = PW'(MAXV - s1_q) * PW'(rhc_pkg::SECTOR_DEG);
  end

  logic v2_q, dir2_q, grey2_q;
  logic [C-1:0] mx2_q, dif2_q, val2_q, a2_q;
  logic [2:0] sec2_q;
  logic [NW-1:0] hnum2_q;
  logic [2*C-1:0] md2_q;
  logic [PW-1:0] fs2_q, gs2_q, ps2_q;

  // stage 3: divider operands
  logic [NW-1:0] n0_d, n1_d, n2_d;
  logic [DW-1:0] d0_d, d1_d, d2_d;
  logic [NW-1:0] vp_d, vq_d, vt_d;

  always_comb begin
    vp_d = NW'(val2_q) * NW'(ps2_q);
    vq_d = NW'(val2_q) * NW'(DEN - fs2_q);
    vt_d = NW'(val2_q) * NW'(DEN - gs2_q);
    if (!dir2_q) begin
      n0_d = (NW'(md2_q) << 1) + NW'(mx2_q);
      d0_d = DW'(mx2_q) << 1;
      n1_d = (hnum2_q << 1) + NW'(dif2_q);
      d1_d = DW'(dif2_q) << 1;
      n2_d = '0;
      d2_d = DW'(1);
    end else begin
      n0_d = (vp_d << 1) + NW'(DEN);
      n1_d = (vq_d << 1) + NW'(DEN);
      n2_d = (vt_d << 1) + NW'(DEN);
      d0_d = DW'(DEN) << 1;
      d1_d = DW'(DEN) << 1;
      d2_d = DW'(DEN) << 1;
    end
  end

  logic v3_q, dir3_q, grey3_q;
  logic [C-1:0] mx3_q, val3_q, a3_q;
  logic [2:0] sec3_q;
  logic [NW-1:0] n0_q, n1_q, n2_q;
  logic [DW-1:0] d0_q, d1_q, d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= pix_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir1_q  <= dir_q;
      r1_q    <= pix_i.red;
      g1_q    <= pix_i.green;
      b1_q    <= pix_i.blue;
      mx1_q   <= mx_d;
      mn1_q   <= mn_d;
      sel1_q  <= sel_d;
      hs1_q   <= hs_d;
      s1_q    <= pix_i.saturation;
      val1_q  <= pix_i.brightness;
      a1_q    <= pix_i.alpha;

      dir2_q  <= dir1_q;
      grey2_q <= (mx1_q == mn1_q);
      mx2_q   <= mx1_q;
      dif2_q  <= dif_d;
      val2_q  <= val1_q;
      a2_q    <= a1_q;
      sec2_q  <= hs1_q.sector;
      hnum2_q <= hnum_d;
      md2_q   <= md_d;
      fs2_q   <= fs_d;
      gs2_q   <= gs_d;
      ps2_q   <= ps_d;

      dir3_q  <= dir2_q;
      grey3_q <= grey2_q;
      mx3_q   <= mx2_q;
      val3_q  <= val2_q;
      a3_q    <= a2_q;
      sec3_q  <= sec2_q;
      n0_q    <= n0_d;
      n1_q    <= n1_d;
      n2_q    <= n2_d;
      d0_q    <= d0_d;
      d1_q    <= d1_d;
      d2_q    <= d2_d;
    end
  end

  // divider pipelines
  logic [QW-1:0] q0, q1, q2;

  rhc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div0 (
    .clk_i(clk_i), .en_i(en), .num_i(n0_q), .den_i(d0_q), .quo_o(q0)
  );
  rhc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div1 (
    .clk_i(clk_i), .en_i(en), .num_i(n1_q), .den_i(d1_q), .quo_o(q1)
  );
  rhc_div #(.NW(NW), .DW(DW), .QW(QW)) u_div2 (
    .clk_i(clk_i), .en_i(en), .num_i(n2_q), .den_i(d2_q), .quo_o(q2)
  );

  // side data alongside the dividers
  logic         sv_q   [QW];
  logic         sdir_q [QW];
  logic         sgrey_q[QW];
  logic [C-1:0] smx_q  [QW];
  logic [C-1:0] sval_q [QW];
  logic [C-1:0] sa_q   [QW];
  logic [2:0]   ssec_q [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) sv_q[k] <= 1'b0;
    end else if (en) begin
      sv_q[0] <= v3_q;
      for (int k = 1; k < QW; k++) sv_q[k] <= sv_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdir_q[0]  <= dir3_q;
      sgrey_q[0] <= grey3_q;
      smx_q[0]   <= mx3_q;
      sval_q[0]  <= val3_q;
      sa_q[0]    <= a3_q;
      ssec_q[0]  <= sec3_q;
      for (int k = 1; k < QW; k++) begin
        sdir_q[k]  <= sdir_q[k-1];
        sgrey_q[k] <= sgrey_q[k-1];
        smx_q[k]   <= smx_q[k-1];
        sval_q[k]  <= sval_q[k-1];
        sa_q[k]    <= sa_q[k-1];
        ssec_q[k]  <= ssec_q[k-1];
      end
    end
  end

  // output stage
  logic [C-1:0]  red_d, green_d, blue_d, sat_d, bri_d;
  logic [HB-1:0] hue_d;
  logic [C-1:0]  pv, qv, tv, vv;

  always_comb begin
    pv = q0[C-1:0];
    qv = q1[C-1:0];
    tv = q2[C-1:0];
    vv = sval_q[QW-1];
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    hue_d   = '0;
    sat_d   = '0;
    bri_d   = '0;
    if (!sdir_q[QW-1]) begin
      bri_d = smx_q[QW-1];
      if (!sgrey_q[QW-1]) begin
        hue_d = q1[HB-1:0];
        sat_d = q0[C-1:0];
      end
    end else begin
      case (ssec_q[QW-1])
        3'd0: begin red_d = vv; green_d = tv; blue_d = pv; end
        3'd1: begin red_d = qv; green_d = vv; blue_d = pv; end
        3'd2: begin red_d = pv; green_d = vv; blue_d = tv; end
        3'd3: begin red_d = pv; green_d = qv; blue_d = vv; end
        3'd4: begin red_d = tv; green_d = pv; blue_d = vv; end
        default: begin red_d = vv; green_d = pv; blue_d = qv; end
      endcase
    end
  end

  logic [C-1:0]  ored_q, ogreen_q, oblue_q, osat_q, obri_q, oa_q;
  logic [HB-1:0] ohue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sv_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ored_q   <= red_d;
      ogreen_q <= green_d;
      oblue_q  <= blue_d;
      ohue_q   <= hue_d;
      osat_q   <= sat_d;
      obri_q   <= bri_d;
      oa_q     <= sa_q[QW-1];
    end
  end

  assign pix_o.valid          = out_vld_q;
  assign pix_o.out_red        = ored_q;
  assign pix_o.out_green      = ogreen_q;
  assign pix_o.out_blue       = oblue_q;
  assign pix_o.out_hue        = ohue_q;
  assign pix_o.out_saturation = osat_q;
  assign pix_o.out_brightness = obri_q;
  assign pix_o.out_alpha      = oa_q;

  `ASSERT_IMPLIES(a_hue_range, clk_i, rst_ni, out_vld_q, ohue_q <= HB'(rhc_pkg::HUE_FULL))
  `ASSERT_IMPLIES(a_hsv_clears_rgb, clk_i, rst_ni, out_vld_q && (obri_q != '0), (ored_q == '0) && (ogreen_q == '0) && (oblue_q == '0))
  `ASSERT_ALWAYS(a_ready_follows_stall, clk_i, rst_ni, pix_i.ready == (!out_vld_q || pix_o.ready))

endmodule

// ===== tb/tb_top.sv =====
// testbench for rgb_hsv_converter: directed and random pixel items in both directions
// depends on rhc_pkg, rhc_if and the converter rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CB = 8;
  localparam int unsigned CMAX = (1 << CB) - 1;
  localparam int unsigned DRAIN = 40;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [8:0] h;
    logic [7:0] s;
    logic [7:0] v;
    logic [7:0] a;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;

  rhc_in_if #(.CHANNEL_BITS(CB)) pix_in ();
  rhc_out_if #(.CHANNEL_BITS(CB)) pix_out ();

  rgb_hsv_converter #(.CHANNEL_BITS(CB)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pix_i(pix_in.sink),
    .pix_o(pix_out.source)
  );

  always #5 clk_i = ~clk_i;

  logic   dir_model;
  pixel_t expected_px[$];
  int     mismatches = 0;
  int     bursty_out = 0;

  function automatic int unsigned rdiv(longint unsigned n, longint unsigned d);
    return int'((2 * n + d) / (2 * d));
  endfunction

  function automatic pixel_t convert_pixel(pixel_t p, logic dir);
    pixel_t o;
    longint unsigned mx, mn, d, num, sec, f, den, pp, qq, tt, r, g, b, h, s, v;
    o = '0;
    o.a = p.a;
    if (!dir) begin
      r = p.r; g = p.g; b = p.b;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      o.v = mx[7:0];
      if (mx != mn) begin
        d = mx - mn;
        o.s = 8'(rdiv(CMAX * d, mx));
        if (mx == r) num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
        else if (mx == g) num = 120 * d + 60 * b - 60 * r;
        else num = 240 * d + 60 * r - 60 * g;
        o.h = 9'(rdiv(num, d));
      end
    end else begin
      h = p.h; s = p.s; v = p.v;
      sec = (h / 60) % 6;
      f = h % 60;
      den = CMAX * 60;
      pp = rdiv(v * (CMAX - s) * 60, den);
      qq = rdiv(v * (den - f * s), den);
      tt = rdiv(v * (den - (60 - f) * s), den);
      case (sec)
        0: begin r = v; g = tt; b = pp; end
        1: begin r = qq; g = v; b = pp; end
        2: begin r = pp; g = v; b = tt; end
        3: begin r = pp; g = qq; b = v; end
        4: begin r = tt; g = pp; b = v; end
        default: begin r = v; g = pp; b = qq; end
      endcase
      o.r = r[7:0]; o.g = g[7:0]; o.b = b[7:0];
    end
    return o;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_pixel(pixel_t p);
    int g;
    g = gap_len();
    if (g != 0) pix_in.valid <= 1'b0;
    repeat (g) @(posedge clk_i);
    pix_in.valid <= 1'b1;
    pix_in.red <= p.r;
    pix_in.green <= p.g;
    pix_in.blue <= p.b;
    pix_in.hue <= p.h;
    pix_in.saturation <= p.s;
    pix_in.brightness <= p.v;
    pix_in.alpha <= p.a;
    do @(posedge clk_i); while (!pix_in.ready);
    expected_px.push_back(convert_pixel(p, dir_model));
  endtask

  task automatic drain_wait();
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_direction(logic dir);
    drain_wait();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= dir;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dir_model = dir;
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = pixel_t'($bits(pixel_t)'({$urandom, $urandom}));
    p.h = 9'($urandom_range(0, 511));
    case ($urandom_range(0, 7))
      0: begin p.g = p.r; p.b = p.r; end
      1: p.g = p.r;
      2: p.b = p.r;
      3: p.b = p.g;
      4: p.h = 9'($urandom_range(0, 360));
      default: ;
    endcase
    return p;
  endfunction

  task automatic test_rgb_to_hsv_directed();
    pixel_t p;
    set_direction(1'b0);
    p = '0; send_pixel(p);
    p = '1; send_pixel(p);
    p = '0; p.r = 8'd255; p.a = 8'd255; send_pixel(p);
    p = '0; p.g = 8'd255; send_pixel(p);
    p = '0; p.b = 8'd255; send_pixel(p);
    p = '0; p.r = 8'd255; p.g = 8'd255; send_pixel(p);
    p = '0; p.g = 8'd255; p.b = 8'd255; send_pixel(p);
    p = '0; p.r = 8'd255; p.b = 8'd255; send_pixel(p);
    p = '0; p.r = 8'd128; p.g = 8'd128; p.b = 8'd128; send_pixel(p);
    p = '0; p.r = 8'd255; p.b = 8'd1; send_pixel(p);
    p = '0; p.r = 8'd255; p.b = 8'd2; send_pixel(p);
    p = '0; p.r = 8'd1; send_pixel(p);
  endtask

  task automatic test_hsv_to_rgb_directed();
    pixel_t p;
    set_direction(1'b1);
    p = '0; send_pixel(p);
    p = '1; send_pixel(p);
    for (int k = 0; k < 9; k++) begin
      p = '0; p.h = 9'(k * 60 + 30); p.s = 8'd255; p.v = 8'd255; p.a = 8'(k);
      send_pixel(p);
    end
    p = '0; p.h = 9'd360; p.s = 8'd200; p.v = 8'd200; send_pixel(p);
    p = '0; p.h = 9'd359; p.s = 8'd255; p.v = 8'd1; send_pixel(p);
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < 6; ph++) begin
      set_direction(logic'(ph & 1));
      bursty_out = ph % 3;
      for (int k = 0; k < 215; k++) send_pixel(rand_pixel());
    end
  endtask

  task automatic check_field(string nm, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d actual %0d", nm, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    pixel_t e;
    if (rst_ni) begin
      if (pix_out.valid && pix_out.ready) begin
        if (expected_px.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: unexpected result item");
        end else begin
          e = expected_px.pop_front();
          check_field("out_red", e.r, pix_out.out_red);
          check_field("out_green", e.g, pix_out.out_green);
          check_field("out_blue", e.b, pix_out.out_blue);
          check_field("out_hue", e.h, pix_out.out_hue);
          check_field("out_saturation", e.s, pix_out.out_saturation);
          check_field("out_brightness", e.v, pix_out.out_brightness);
          check_field("out_alpha", e.a, pix_out.out_alpha);
        end
      end
      if (bursty_out == 0) pix_out.ready <= 1'b1;
      else if (pix_out.ready) pix_out.ready <= ($urandom_range(0, 99) < 70);
      else pix_out.ready <= ($urandom_range(0, 99) < (bursty_out == 1 ? 50 : 5));
    end else begin
      pix_out.ready <= 1'b0;
    end
  end

  initial begin
    pix_in.valid = 1'b0;
    pix_in.red = '0;
    pix_in.green = '0;
    pix_in.blue = '0;
    pix_in.hue = '0;
    pix_in.saturation = '0;
    pix_in.brightness = '0;
    pix_in.alpha = '0;
    dir_model = 1'b0;
    bursty_out = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_rgb_to_hsv_directed();
    test_hsv_to_rgb_directed();
    test_random_mix();
    drain_wait();
    if (mismatches == 0 && expected_px.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rhc_pkg.sv
hw/rtl/rhc_if.sv
hw/rtl/rhc_div.sv
hw/rtl/rgb_hsv_converter.sv
tb/tb_top.sv
